FILE: hw/rtl/nbct_pkg.sv
// Shared types, codes and constants for the naive Bayes count trainer.
// No dependencies; the RTL files refer to this package by scoped names, the test files import it.
package nbct_pkg;

  localparam int DEF_MAX_CLASSES  = 16;
  localparam int DEF_MAX_FEATURES = 64;

  localparam int NUM_FEATURES_W = 7;
  localparam int NUM_CLASSES_W  = 5;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 7;
  localparam int VALUE_W        = 32;
  localparam int TOTAL_W        = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_FEATURES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_CLASSES  = 1'd1;

  localparam logic [NUM_FEATURES_W-1:0] NUM_FEATURES_RST = 7'd64;
  localparam logic [NUM_CLASSES_W-1:0]  NUM_CLASSES_RST  = 5'd16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_TRAIN = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] status;
    logic       sum_we;
    logic       tally_inc;
    logic       show;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: hw/rtl/nbct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nbct_pkg for the address width helper.
module nbct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = nbct_pkg::addr_width(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/nbct_front.sv
// Front end: configuration registers, sample framing and request classification.
// Depends on nbct_pkg; feeds the request queue with control and addresses.
module nbct_front #(
  parameter int MAX_CLASSES  = nbct_pkg::DEF_MAX_CLASSES,
  parameter int MAX_FEATURES = nbct_pkg::DEF_MAX_FEATURES,
  localparam int SUM_AW   = nbct_pkg::addr_width(MAX_CLASSES * MAX_FEATURES),
  localparam int TALLY_AW = nbct_pkg::addr_width(MAX_CLASSES),
  localparam int POS_W    = nbct_pkg::addr_width(MAX_FEATURES)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [nbct_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nbct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic [1:0]                         command,
  input  logic [7:0]                         class_label,
  input  logic [5:0]                         feature_index,
  output nbct_pkg::ctl_t                     ctl,
  output logic [SUM_AW-1:0]                  sum_addr,
  output logic [TALLY_AW-1:0]                tally_addr
);

  logic [nbct_pkg::NUM_FEATURES_W-1:0] num_features;
  logic [nbct_pkg::NUM_CLASSES_W-1:0]  num_classes;
  logic [POS_W-1:0]                    position;
  logic [7:0]                          held_class;
  logic                                skipping;

  logic [nbct_pkg::NUM_FEATURES_W-1:0] eff_features;
  logic [nbct_pkg::NUM_CLASSES_W-1:0]  eff_classes;
  logic                                first;
  logic                                last;
  logic [7:0]                          cur_class;
  logic                                cur_skip;
  logic                                read_ok;

  always_comb begin
    if (int'(num_classes) > MAX_CLASSES) begin
      eff_classes = nbct_pkg::NUM_CLASSES_W'(MAX_CLASSES);
    end else begin
      eff_classes = num_classes;
    end
    if (num_features == '0) begin
      eff_features = nbct_pkg::NUM_FEATURES_W'(1);
    end else if (int'(num_features) > MAX_FEATURES) begin
      eff_features = nbct_pkg::NUM_FEATURES_W'(MAX_FEATURES);
    end else begin
      eff_features = num_features;
    end
    first     = (position == '0);
    cur_class = first ? class_label : held_class;
    cur_skip  = first ? (class_label >= 8'(eff_classes)) : skipping;
    last      = (int'(position) + 1) >= int'(eff_features);
    read_ok   = (int'(class_label) < MAX_CLASSES) && (int'(feature_index) < MAX_FEATURES);

    ctl.op        = command;
    ctl.status    = nbct_pkg::ST_COUNTED;
    ctl.sum_we    = 1'b0;
    ctl.tally_inc = 1'b0;
    ctl.show      = 1'b0;
    sum_addr      = '0;
    tally_addr    = '0;
    unique case (command)
      nbct_pkg::CMD_TRAIN: begin
        if (cur_skip) begin
          ctl.status = nbct_pkg::ST_SKIPPED;
        end else begin
          ctl.status    = last ? nbct_pkg::ST_DONE : nbct_pkg::ST_COUNTED;
          ctl.sum_we    = 1'b1;
          ctl.tally_inc = first;
          sum_addr      = SUM_AW'(int'(cur_class) * MAX_FEATURES + int'(position));
          tally_addr    = TALLY_AW'(cur_class);
        end
      end
      nbct_pkg::CMD_READ: begin
        ctl.status = nbct_pkg::ST_READ;
        if (read_ok) begin
          ctl.show   = 1'b1;
          sum_addr   = SUM_AW'(int'(class_label) * MAX_FEATURES + int'(feature_index));
          tally_addr = TALLY_AW'(class_label);
        end
      end
      nbct_pkg::CMD_CLEAR, nbct_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_features <= nbct_pkg::NUM_FEATURES_RST;
      num_classes  <= nbct_pkg::NUM_CLASSES_RST;
      position     <= '0;
      held_class   <= '0;
      skipping     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          nbct_pkg::REG_NUM_FEATURES: num_features <= cfg_data;
          nbct_pkg::REG_NUM_CLASSES:
            num_classes <= cfg_data[nbct_pkg::NUM_CLASSES_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (command == nbct_pkg::CMD_CLEAR) begin
          position   <= '0;
          held_class <= '0;
          skipping   <= 1'b0;
        end else if (command == nbct_pkg::CMD_TRAIN) begin
          held_class <= cur_class;
          skipping   <= cur_skip;
          position   <= last ? '0 : POS_W'(position + 1'b1);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/nbct_queue.sv
// Two-entry request queue between the front and back ends.
// Does not depend on nbct_pkg; only its width is set by the modules around it.
module nbct_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= 2'(count + 2'd1);
        2'b01:   count <= 2'(count - 2'd1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/nbct_back.sv
// Back end: count memories, clearing sweep, read-modify-write and result register.
// Depends on nbct_pkg and nbct_ram.
module nbct_back #(
  parameter int MAX_CLASSES  = nbct_pkg::DEF_MAX_CLASSES,
  parameter int MAX_FEATURES = nbct_pkg::DEF_MAX_FEATURES,
  localparam int SUM_DEPTH = MAX_CLASSES * MAX_FEATURES,
  localparam int SUM_AW    = nbct_pkg::addr_width(SUM_DEPTH),
  localparam int TALLY_AW  = nbct_pkg::addr_width(MAX_CLASSES)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_pop,
  input  nbct_pkg::ctl_t                     q_ctl,
  input  logic [SUM_AW-1:0]                  q_sum_addr,
  input  logic [TALLY_AW-1:0]                q_tally_addr,
  input  logic [nbct_pkg::VALUE_W-1:0]       q_value,
  output logic                               sweep_busy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [nbct_pkg::TOTAL_W-1:0]       feature_total,
  output logic [nbct_pkg::TOTAL_W-1:0]       class_total
);

  logic [SUM_AW-1:0]               sweep_addr;

  logic                            b_valid;
  nbct_pkg::ctl_t                  b_ctl;
  logic [SUM_AW-1:0]               b_sum_addr;
  logic [TALLY_AW-1:0]             b_tally_addr;
  logic [nbct_pkg::VALUE_W-1:0]    b_value;
  logic                            b_fwd_sum;
  logic [nbct_pkg::TOTAL_W-1:0]    b_fwd_sum_data;
  logic                            b_fwd_tally;
  logic [nbct_pkg::TOTAL_W-1:0]    b_fwd_tally_data;

  logic [nbct_pkg::TOTAL_W-1:0]    sum_rd;
  logic [nbct_pkg::TOTAL_W-1:0]    tally_rd;
  logic [nbct_pkg::TOTAL_W-1:0]    sum_cur;
  logic [nbct_pkg::TOTAL_W-1:0]    tally_cur;
  logic                            sum_we;
  logic [SUM_AW-1:0]               sum_waddr;
  logic [nbct_pkg::TOTAL_W-1:0]    sum_wdata;
  logic                            tally_we;
  logic [TALLY_AW-1:0]             tally_waddr;
  logic [nbct_pkg::TOTAL_W-1:0]    tally_wdata;
  logic                            b_done;
  logic                            b_free;
  logic                            b_clear;

  assign b_clear = b_valid && (b_ctl.op == nbct_pkg::CMD_CLEAR);
  assign b_done  = b_valid && (!out_valid || out_ready);
  assign b_free  = !b_valid || b_done;
  assign q_pop   = q_valid && !sweep_busy && !b_clear && b_free;

  assign sum_cur   = b_fwd_sum ? b_fwd_sum_data : sum_rd;
  assign tally_cur = b_fwd_tally ? b_fwd_tally_data : tally_rd;

  always_comb begin
    if (sweep_busy) begin
      sum_we      = 1'b1;
      sum_waddr   = sweep_addr;
      sum_wdata   = '0;
      tally_we    = int'(sweep_addr) < MAX_CLASSES;
      tally_waddr = TALLY_AW'(sweep_addr);
      tally_wdata = '0;
    end else begin
      sum_we      = b_done && b_ctl.sum_we;
      sum_waddr   = b_sum_addr;
      sum_wdata   = sum_cur + nbct_pkg::TOTAL_W'(b_value);
      tally_we    = b_done && b_ctl.tally_inc;
      tally_waddr = b_tally_addr;
      tally_wdata = tally_cur + nbct_pkg::TOTAL_W'(1);
    end
  end

  nbct_ram #(
    .WIDTH(nbct_pkg::TOTAL_W),
    .DEPTH(SUM_DEPTH)
  ) u_sum_ram (
    .clk  (clk),
    .we   (sum_we),
    .waddr(sum_waddr),
    .wdata(sum_wdata),
    .re   (q_pop),
    .raddr(q_sum_addr),
    .rdata(sum_rd)
  );

  nbct_ram #(
    .WIDTH(nbct_pkg::TOTAL_W),
    .DEPTH(MAX_CLASSES)
  ) u_tally_ram (
    .clk  (clk),
    .we   (tally_we),
    .waddr(tally_waddr),
    .wdata(tally_wdata),
    .re   (q_pop),
    .raddr(q_tally_addr),
    .rdata(tally_rd)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_ctl            <= q_ctl;
      b_sum_addr       <= q_sum_addr;
      b_tally_addr     <= q_tally_addr;
      b_value          <= q_value;
      b_fwd_sum_data   <= sum_wdata;
      b_fwd_tally_data <= tally_wdata;
    end
    if (b_done) begin
      status        <= b_ctl.status;
      feature_total <= b_ctl.show ? sum_cur : '0;
      class_total   <= b_ctl.show ? tally_cur : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_busy  <= 1'b1;
      sweep_addr  <= '0;
      b_valid     <= 1'b0;
      b_fwd_sum   <= 1'b0;
      b_fwd_tally <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (sweep_busy) begin
        if (sweep_addr == SUM_AW'(SUM_DEPTH - 1)) begin
          sweep_busy <= 1'b0;
          sweep_addr <= '0;
        end else begin
          sweep_addr <= SUM_AW'(sweep_addr + 1'b1);
        end
      end else if (b_done && b_clear) begin
        sweep_busy <= 1'b1;
        sweep_addr <= '0;
      end
      if (q_pop) begin
        b_valid     <= 1'b1;
        b_fwd_sum   <= sum_we && (sum_waddr == q_sum_addr);
        b_fwd_tally <= tally_we && (tally_waddr == q_tally_addr);
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/naive_bayes_count_trainer.sv
// Naive Bayes count trainer: front end, request queue and back end.
// A result is registered on the outputs after its request has passed the queue and back end.
// Throughput: one request per cycle while out_ready is high and no clearing sweep runs.
// A clear request sweeps all MAX_CLASSES*MAX_FEATURES sum addresses (1024 by default) with in_ready low.
// Reset: synchronous; the same sweep follows reset before the first request is taken.
module naive_bayes_count_trainer #(
  parameter int MAX_CLASSES  = nbct_pkg::DEF_MAX_CLASSES,
  parameter int MAX_FEATURES = nbct_pkg::DEF_MAX_FEATURES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [nbct_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nbct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic [7:0]                         class_label,
  input  logic [5:0]                         feature_index,
  input  logic [nbct_pkg::VALUE_W-1:0]       feature_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [nbct_pkg::TOTAL_W-1:0]       feature_total,
  output logic [nbct_pkg::TOTAL_W-1:0]       class_total
);

  localparam int SUM_AW   = nbct_pkg::addr_width(MAX_CLASSES * MAX_FEATURES);
  localparam int TALLY_AW = nbct_pkg::addr_width(MAX_CLASSES);
  localparam int Q_W      = nbct_pkg::CTL_W + SUM_AW + TALLY_AW + nbct_pkg::VALUE_W;

  logic                          accept;
  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;
  logic                          sweep_busy;
  nbct_pkg::ctl_t                f_ctl;
  logic [SUM_AW-1:0]             f_sum_addr;
  logic [TALLY_AW-1:0]           f_tally_addr;
  logic [Q_W-1:0]                q_din;
  logic [Q_W-1:0]                q_dout;
  nbct_pkg::ctl_t                q_ctl;
  logic [SUM_AW-1:0]             q_sum_addr;
  logic [TALLY_AW-1:0]           q_tally_addr;
  logic [nbct_pkg::VALUE_W-1:0]  q_value;

  assign in_ready = !q_full && !sweep_busy;
  assign accept   = in_valid && in_ready;
  assign q_din    = {f_ctl, f_sum_addr, f_tally_addr, feature_value};
  assign {q_ctl, q_sum_addr, q_tally_addr, q_value} = q_dout;

  nbct_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .command      (command),
    .class_label  (class_label),
    .feature_index(feature_index),
    .ctl          (f_ctl),
    .sum_addr     (f_sum_addr),
    .tally_addr   (f_tally_addr)
  );

  nbct_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  nbct_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_FEATURES(MAX_FEATURES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_ctl        (q_ctl),
    .q_sum_addr   (q_sum_addr),
    .q_tally_addr (q_tally_addr),
    .q_value      (q_value),
    .sweep_busy   (sweep_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .feature_total(feature_total),
    .class_total  (class_total)
  );

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> !accept)
    else $error("request accepted during clearing sweep");

  a_totals_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != nbct_pkg::ST_READ) |-> (feature_total == '0 && class_total == '0))
    else $error("nonzero totals on a non-read result");

  a_sweep_after_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(sweep_busy) |-> (out_valid && status == nbct_pkg::ST_COUNTED))
    else $error("clearing sweep started without a clear result");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> !q_pop)
    else $error("queue popped during clearing sweep");
`endif

endmodule

FILE: test/naive_bayes_count_trainer_checker.sv
// Checker for the naive Bayes count trainer: watches the config port and the
// request and result channels, keeps its own copy of the count tables and compares every result.
// Depends on nbct_pkg for codes and widths.
module naive_bayes_count_trainer_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [nbct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nbct_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [7:0]                    class_label,
  input  logic [5:0]                    feature_index,
  input  logic [nbct_pkg::VALUE_W-1:0]  feature_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    status,
  input  logic [nbct_pkg::TOTAL_W-1:0]  feature_total,
  input  logic [nbct_pkg::TOTAL_W-1:0]  class_total,
  output int                            errors,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import nbct_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [TOTAL_W-1:0] feature_total;
    logic [TOTAL_W-1:0] class_total;
  } count_result_t;

  count_result_t awaited_results[$];

  logic [TOTAL_W-1:0] feature_sums [0:DEF_MAX_CLASSES*DEF_MAX_FEATURES-1];
  logic [TOTAL_W-1:0] class_tallies [0:DEF_MAX_CLASSES-1];
  int                 frame_pos;
  logic [7:0]         held_class;
  logic               skipping;
  logic [NUM_FEATURES_W-1:0] features_reg;
  logic [NUM_CLASSES_W-1:0]  classes_reg;
  int                 mismatch_count = 0;

  task automatic wipe_counts();
    for (int i = 0; i < DEF_MAX_CLASSES*DEF_MAX_FEATURES; i++) feature_sums[i] = '0;
    for (int i = 0; i < DEF_MAX_CLASSES; i++) class_tallies[i] = '0;
    frame_pos = 0;
    held_class = '0;
    skipping = 1'b0;
  endtask

  task automatic apply_request(input logic [1:0] cmd, input logic [7:0] lbl,
                               input logic [5:0] fidx, input logic [VALUE_W-1:0] val,
                               output count_result_t res);
    int span;
    int class_limit;
    res = '0;
    res.status = ST_COUNTED;
    case (cmd)
      CMD_CLEAR: wipe_counts();
      CMD_TRAIN: begin
        span = (features_reg == 0) ? 1 :
               (features_reg > DEF_MAX_FEATURES) ? DEF_MAX_FEATURES : int'(features_reg);
        class_limit = (classes_reg > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : int'(classes_reg);
        if (frame_pos == 0) begin
          held_class = lbl;
          skipping = (int'(lbl) >= class_limit);
          if (!skipping) class_tallies[held_class] += 1;
        end
        if (skipping) begin
          res.status = ST_SKIPPED;
        end else if (held_class < DEF_MAX_CLASSES && frame_pos < DEF_MAX_FEATURES) begin
          feature_sums[int'(held_class) * DEF_MAX_FEATURES + frame_pos] += val;
        end
        if (frame_pos + 1 >= span) begin
          frame_pos = 0;
          if (!skipping) res.status = ST_DONE;
        end else begin
          frame_pos++;
        end
      end
      CMD_READ: begin
        res.status = ST_READ;
        if (lbl < DEF_MAX_CLASSES && fidx < DEF_MAX_FEATURES) begin
          res.feature_total = feature_sums[int'(lbl) * DEF_MAX_FEATURES + int'(fidx)];
          res.class_total = class_tallies[lbl];
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    count_result_t want;
    count_result_t predicted;
    if (rst) begin
      wipe_counts();
      features_reg = NUM_FEATURES_RST;
      classes_reg = NUM_CLASSES_RST;
      awaited_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_NUM_FEATURES) features_reg = cfg_data[NUM_FEATURES_W-1:0];
        else classes_reg = cfg_data[NUM_CLASSES_W-1:0];
      end
      if (in_valid && in_ready) begin
        apply_request(command, class_label, feature_index, feature_value, predicted);
        awaited_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result status=%0d feature_total=%h class_total=%h",
                     $realtime, status, feature_total, class_total);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status || feature_total !== want.feature_total ||
              class_total !== want.class_total) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: exp st=%0d ft=%h ct=%h, got st=%0d ft=%h ct=%h",
                       $realtime, want.status, want.feature_total, want.class_total,
                       status, feature_total, class_total);
          end
        end
      end
    end
    errors <= mismatch_count;
    outstanding <= awaited_results.size();
  end

endmodule

FILE: test/naive_bayes_count_trainer_tb.sv
// Top of the naive Bayes count trainer testbench: clock, reset, request stimulus,
// output back-pressure, watchdog and verdict.
// Depends on nbct_pkg, naive_bayes_count_trainer and naive_bayes_count_trainer_checker.
module naive_bayes_count_trainer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nbct_pkg::*;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int QUIET_LIMIT     = 5000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             command = CMD_NOP;
  logic [7:0]             class_label = '0;
  logic [5:0]             feature_index = '0;
  logic [VALUE_W-1:0]     feature_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [TOTAL_W-1:0]     feature_total;
  logic [TOTAL_W-1:0]     class_total;

  int errors;
  int outstanding;
  int requests_sent = 0;
  int burst_left = 0;
  int features_eff = DEF_MAX_FEATURES;
  int classes_eff = DEF_MAX_CLASSES;
  int ready_mode = 0;
  int ready_left = 0;
  int quiet_cycles = 0;

  naive_bayes_count_trainer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .class_label(class_label),
    .feature_index(feature_index), .feature_value(feature_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .feature_total(feature_total), .class_total(class_total)
  );

  naive_bayes_count_trainer_checker count_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .class_label(class_label),
    .feature_index(feature_index), .feature_value(feature_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .feature_total(feature_total), .class_total(class_total),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(10, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_request(input logic [1:0] cmd, input logic [7:0] lbl,
                              input logic [5:0] fidx, input logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    class_label <= lbl;
    feature_index <= fidx;
    feature_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != CMD_NOP) requests_sent++;
  endtask

  // hold off until every request has its result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [NUM_FEATURES_W-1:0] nf,
                                input logic [NUM_CLASSES_W-1:0] nc);
    cfg_write <= 1'b1;
    cfg_index <= REG_NUM_FEATURES;
    cfg_data <= nf;
    @(posedge clk);
    cfg_index <= REG_NUM_CLASSES;
    cfg_data <= {2'($urandom), nc};
    @(posedge clk);
    cfg_write <= 1'b0;
    features_eff = (nf == 0) ? 1 : (nf > DEF_MAX_FEATURES) ? DEF_MAX_FEATURES : int'(nf);
    classes_eff = (nc > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : int'(nc);
  endtask

  task automatic run_phase(input int quota);
    int done_here;
    int len;
    int pick;
    logic [7:0] lbl;
    done_here = 0;
    while (done_here < quota) begin
      pick = $urandom_range(0, 999);
      if (pick < 8) begin
        push_request(CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom);
        done_here++;
      end else if (pick < 650) begin
        if (classes_eff == 0 || $urandom_range(0, 6) == 0)
          lbl = 8'($urandom_range(classes_eff, 255));
        else
          lbl = 8'($urandom_range(0, classes_eff - 1));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, features_eff) : features_eff;
        for (int k = 0; k < len; k++) begin
          push_request(CMD_TRAIN, (k == 0) ? lbl : 8'($urandom), 6'($urandom), rand_value());
          if ($urandom_range(0, 19) == 0)
            push_request(CMD_READ, 8'($urandom_range(0, 15)), 6'($urandom), rand_value());
        end
        done_here += len;
      end else if (pick < 880) begin
        if ($urandom_range(0, 4) == 0)
          push_request(CMD_READ, 8'($urandom), 6'($urandom), rand_value());
        else
          push_request(CMD_READ, 8'($urandom_range(0, 15)),
                       6'($urandom_range(0, features_eff - 1)), rand_value());
        done_here++;
      end else if (pick < 930) begin
        push_request(CMD_NOP, 8'($urandom), 6'($urandom), $urandom);
      end else begin
        push_request(CMD_TRAIN, 8'($urandom), 6'($urandom), rand_value());
        done_here++;
      end
    end
  endtask

  initial begin
    int base;
    int phase_idx;
    logic [NUM_FEATURES_W-1:0] nf;
    logic [NUM_CLASSES_W-1:0] nc;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    apply_settings(7'd2, 5'd3);

    push_request(CMD_READ, 8'd0, 6'd0, '0);
    push_request(CMD_TRAIN, 8'd1, 6'($urandom), 32'hFFFF_FFFF);
    push_request(CMD_TRAIN, 8'hFF, 6'd63, '0);
    push_request(CMD_TRAIN, 8'd1, 6'd0, 32'hFFFF_FFFF);
    push_request(CMD_READ, 8'd1, 6'd0, '0);
    push_request(CMD_TRAIN, 8'd0, 6'd0, 32'd1);
    push_request(CMD_READ, 8'd1, 6'd0, '0);
    push_request(CMD_READ, 8'd1, 6'd1, '0);
    push_request(CMD_TRAIN, 8'd3, 6'd0, 32'd5);
    push_request(CMD_TRAIN, 8'd0, 6'd0, 32'd7);
    push_request(CMD_TRAIN, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    push_request(CMD_TRAIN, 8'd2, 6'd0, 32'd3);
    push_request(CMD_READ, 8'd16, 6'd0, '0);
    push_request(CMD_READ, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    push_request(CMD_READ, 8'd1, 6'd63, '0);
    push_request(CMD_READ, 8'd15, 6'd63, '0);
    push_request(CMD_NOP, 8'hAA, 6'h15, 32'h5555_AAAA);
    push_request(CMD_CLEAR, 8'd1, 6'd0, '0);
    push_request(CMD_READ, 8'd1, 6'd0, '0);
    push_request(CMD_TRAIN, 8'd2, 6'd0, 32'd9);
    push_request(CMD_TRAIN, 8'd0, 6'd0, '0);
    push_request(CMD_READ, 8'd2, 6'd0, '0);
    drain();

    base = requests_sent;
    phase_idx = 0;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      case (phase_idx)
        0: begin nf = 7'd127; nc = 5'd31; end
        1: begin nf = 7'd0;   nc = 5'd0;  end
        2: begin nf = 7'd1;   nc = 5'd2;  end
        3: begin nf = 7'd64;  nc = 5'd16; end
        4: begin nf = 7'd3;   nc = 5'd1;  end
        default: begin
          case ($urandom_range(0, 9))
            0: nf = 7'd0;
            1: nf = 7'd64;
            2: nf = 7'($urandom_range(65, 127));
            3: nf = 7'd1;
            default: nf = 7'($urandom_range(2, 8));
          endcase
          case ($urandom_range(0, 9))
            0: nc = 5'd0;
            1: nc = 5'd1;
            2: nc = 5'd16;
            3: nc = 5'($urandom_range(17, 31));
            4: nc = 5'd2;
            default: nc = 5'($urandom_range(2, 15));
          endcase
        end
      endcase
      apply_settings(nf, nc);
      run_phase($urandom_range(20, 120));
      drain();
      phase_idx++;
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
